FILE: sv/spwi_pkg.sv
// Shared constants, register codes and divider handshake types for the
// servo position loop. No dependencies.
package spwi_pkg;

  localparam int WINDOW_LENGTH_DEF = 16;

  // Field widths
  localparam int POS_W   = 10;
  localparam int IVL_W   = 16;
  localparam int ERR_W   = 11;
  localparam int DIFF_W  = 12;
  localparam int GAIN_W  = 16;
  localparam int MPWR_W  = 9;
  localparam int MAG_W   = 8;

  // Internal term widths
  localparam int TERM_W  = 18;   // p and i after the Q8.8 shift
  localparam int DTERM_W = 20;   // d after division by 256*interval
  localparam int TOT_W   = 21;   // p + i + d
  localparam int DRIVE_W = 18;   // drive before clamp
  localparam int MUL_A_W = 21;
  localparam int PROD_W  = MUL_A_W + GAIN_W;
  localparam int DIV_W   = 28;

  localparam int SCALE_NUM = 255;
  localparam int SCALE_DEN = 1023;

  // Ports
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 24;

  typedef enum logic [2:0] {
    REG_POSITION_MODE = 3'd0,
    REG_GOAL_POSITION = 3'd1,
    REG_MANUAL_POWER  = 3'd2,
    REG_GAIN_P        = 3'd3,
    REG_GAIN_I        = 3'd4,
    REG_GAIN_D        = 3'd5,
    REG_MAX_POWER     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: sv/spwi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module spwi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/spwi_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on spwi_pkg.
module spwi_div (
  input  logic              clk,
  input  logic              rst,
  input  spwi_pkg::div_req_t req,
  output spwi_pkg::div_rsp_t rsp
);
  import spwi_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   trial;

  assign shifted = {rem[DIV_W-1:0], quo[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!trial[DIV_W]) begin
        rem <= trial;
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: sv/servo_pid_window_integral.sv
// Servo position loop with a PID whose I term is a moving-window average.
// Depends on spwi_pkg, spwi_ram and spwi_div.
//
// Each transfer on the s_ side is one loop tick (position sample and the
// previous interval in ms) and yields exactly one transfer on the m_ side
// (drive magnitude, direction bits and the echoed position). In manual power
// mode a tick goes straight from idle to the clamp step; in position mode it
// runs the whole sequence. The 28-step restoring divider is used only for the
// derivative division by 256*interval. The window average is a reciprocal
// multiply followed by a one-step remainder fix, and the 255/1023 output
// scaling is a multiply by 255 followed by a shift-add estimate of the
// division by 1023 and the same fix. A single 21x16 multiplier forms the
// three gain products, the reciprocal product and the scaling product in
// turn. s_tready is high only while the sequencer is idle; a finished result
// sits in the output register, so the next tick can be taken before the
// previous result is collected. A tick that finishes while that register is
// still full waits in the clamp step until m_ takes the previous result. The
// error window lives in a RAM of WINDOW_LENGTH entries with a valid bit per
// entry, so reset, gain writes and entry into position mode clear it at once.
// Configuration writes are expected only while no tick is in flight.
module servo_pid_window_integral #(
  parameter int WINDOW_LENGTH = spwi_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spwi_pkg::CFG_AW-1:0]   paddr,
  input  logic [spwi_pkg::CFG_DW-1:0]   pwdata,
  output logic [spwi_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  // tick input
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [9:0] position_sample, [25:10] interval_ms, rest zero
  input  logic [spwi_pkg::S_DATA_W-1:0] s_tdata,
  // drive output
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [7:0] drive_magnitude, [8] drive_forward, [9] drive_reverse,
  // [19:10] measured_position, rest zero
  output logic [spwi_pkg::M_DATA_W-1:0] m_tdata
);
  import spwi_pkg::*;

  localparam int WIN_AW    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int SUM_W     = ERR_W + $clog2(WINDOW_LENGTH);
  localparam int SUM_LIMIT = (2**POS_W - 1) * WINDOW_LENGTH;
  localparam logic [WIN_AW-1:0] LAST_SLOT = WIN_AW'(WINDOW_LENGTH - 1);

  // Window average: |sum| < 2**(SUM_W-1), so with this shift the reciprocal
  // error over the whole sum stays under 1/16 and the estimate is at most
  // one low.
  localparam int AVG_SHIFT = 14 + $clog2(WINDOW_LENGTH);
  localparam int AVG_RECIP = (2**AVG_SHIFT) / WINDOW_LENGTH;

  // SCALE_DEN is 2**SCALE_SH - 1: x/1023 ~ (x + x>>10 + x>>20) >> 10, at most
  // one low for a 28-bit x.
  localparam int SCALE_SH = $clog2(SCALE_DEN);

  typedef enum logic [12:0] {
    ST_IDLE      = 13'b0_0000_0000_0001,
    ST_WIN       = 13'b0_0000_0000_0010,
    ST_AVG_MUL   = 13'b0_0000_0000_0100,
    ST_AVG_EST   = 13'b0_0000_0000_1000,
    ST_AVG_FIX   = 13'b0_0000_0001_0000,
    ST_MUL_I     = 13'b0_0000_0010_0000,
    ST_MUL_D     = 13'b0_0000_0100_0000,
    ST_D_GO      = 13'b0_0000_1000_0000,
    ST_D_DIV     = 13'b0_0001_0000_0000,
    ST_SCALE_MUL = 13'b0_0010_0000_0000,
    ST_SCALE_EST = 13'b0_0100_0000_0000,
    ST_SCALE_FIX = 13'b0_1000_0000_0000,
    ST_CLAMP     = 13'b1_0000_0000_0000
  } state_t;

  // Truncate a Q8.8 product toward zero.
  function automatic logic signed [TERM_W-1:0] shr8_tz(input logic signed [PROD_W-1:0] x);
    logic signed [PROD_W-1:0] t;
    t = x + (x[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
    return TERM_W'(t >>> 8);
  endfunction

  state_t state;

  // configuration registers
  logic                     position_mode;
  logic [POS_W-1:0]         goal_position;
  logic signed [MPWR_W-1:0] manual_power;
  logic signed [GAIN_W-1:0] gain_p;
  logic signed [GAIN_W-1:0] gain_i;
  logic signed [GAIN_W-1:0] gain_d;
  logic [MAG_W-1:0]         max_power;

  // loop state
  logic [WIN_AW-1:0]        win_idx;
  logic [WIN_AW-1:0]        win_idx_next;
  logic [WINDOW_LENGTH-1:0] win_valid;
  logic signed [SUM_W-1:0]  err_sum;
  logic signed [ERR_W-1:0]  prev_err;

  // datapath registers
  logic [POS_W-1:0]          pos_r;
  logic [IVL_W-1:0]          ivl_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [ERR_W-1:0]   avg_r;
  logic signed [TERM_W-1:0]  p_r;
  logic signed [TERM_W-1:0]  i_r;
  logic signed [TOT_W-1:0]   tot_r;
  logic signed [DRIVE_W-1:0] drive_r;
  logic signed [PROD_W-1:0]  prod;
  logic                      q_neg;
  logic [DRIVE_W-1:0]        q_est;

  // output register
  logic [MAG_W-1:0] out_mag;
  logic             out_fwd;
  logic [POS_W-1:0] out_pos;

  // combinational
  logic                      cfg_wr;
  reg_idx_t                  cfg_idx;
  logic                      win_clear;
  logic                      s_acc;
  logic [POS_W-1:0]          s_pos;
  logic [IVL_W-1:0]          s_ivl;
  logic signed [ERR_W-1:0]   err_new;
  logic [ERR_W-1:0]          ram_rdata;
  logic signed [ERR_W-1:0]   old_err;
  logic signed [SUM_W-1:0]   sum_new;
  logic [SUM_W-1:0]          sum_mag;
  logic [PROD_W-1:0]         prod_mag;
  logic signed [DIFF_W-1:0]  err_diff;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [GAIN_W-1:0]  mul_b;
  logic [SUM_W:0]            avg_rem;
  logic                      avg_bump;
  logic [DIV_W-1:0]          scl_x;
  logic [DIV_W:0]            scl_t;
  logic [DIV_W:0]            scl_rem;
  logic                      scl_bump;
  logic                      fix_bump;
  logic [DRIVE_W-1:0]        q_fix;
  logic signed [DRIVE_W:0]   q_signed;
  logic signed [DIV_W:0]     q_s;
  logic signed [DIV_W:0]     d_signed;
  logic signed [DTERM_W-1:0] d_term;
  logic                      drv_neg;
  logic [DRIVE_W-1:0]        drv_mag;
  logic [MAG_W-1:0]          mag_clamped;
  logic                      out_load;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

  // Gain writes and entry into position mode restart the window.
  assign win_clear = cfg_wr &&
                     ((cfg_idx == REG_GAIN_P) || (cfg_idx == REG_GAIN_I) ||
                      (cfg_idx == REG_GAIN_D) ||
                      ((cfg_idx == REG_POSITION_MODE) && pwdata[0] && !position_mode));

  always_comb begin
    case (cfg_idx)
      REG_POSITION_MODE: prdata = CFG_DW'(position_mode);
      REG_GOAL_POSITION: prdata = CFG_DW'(goal_position);
      REG_MANUAL_POWER:  prdata = CFG_DW'(manual_power);
      REG_GAIN_P:        prdata = CFG_DW'(gain_p);
      REG_GAIN_I:        prdata = CFG_DW'(gain_i);
      REG_GAIN_D:        prdata = CFG_DW'(gain_d);
      REG_MAX_POWER:     prdata = CFG_DW'(max_power);
      default:           prdata = '0;
    endcase
  end

  // ---------------- input side ----------------
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign s_pos    = s_tdata[POS_W-1:0];
  assign s_ivl    = s_tdata[POS_W +: IVL_W];
  assign err_new  = $signed({1'b0, s_pos}) - $signed({1'b0, goal_position});

  // ---------------- error window ----------------
  // Slot advances on accept; the RAM read of that slot lands in ST_WIN.
  assign win_idx_next = (win_idx == LAST_SLOT) ? '0 : win_idx + 1'b1;

  spwi_ram #(
    .WIDTH (ERR_W),
    .DEPTH (WINDOW_LENGTH)
  ) u_window (
    .clk   (clk),
    .we    (state == ST_WIN),
    .waddr (win_idx),
    .wdata (err_r),
    .raddr (win_idx_next),
    .rdata (ram_rdata)
  );

  assign old_err  = win_valid[win_idx] ? $signed(ram_rdata) : ERR_W'(0);
  assign sum_new  = err_sum + SUM_W'(err_r) - SUM_W'(old_err);
  assign sum_mag  = err_sum[SUM_W-1] ? -err_sum : err_sum;
  assign prod_mag = prod[PROD_W-1] ? -prod : prod;
  assign err_diff = DIFF_W'(err_r) - DIFF_W'(prev_err);

  // ---------------- shared multiplier ----------------
  always_comb begin
    mul_en = 1'b1;
    case (state)
      ST_WIN: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = gain_p;
      end
      ST_AVG_MUL: begin
        mul_a = MUL_A_W'(sum_mag);
        mul_b = GAIN_W'(AVG_RECIP);
      end
      ST_MUL_I: begin
        mul_a = MUL_A_W'(avg_r);
        mul_b = gain_i;
      end
      ST_MUL_D: begin
        mul_a = MUL_A_W'(err_diff);
        mul_b = gain_d;
      end
      ST_SCALE_MUL: begin
        mul_a = MUL_A_W'(tot_r);
        mul_b = GAIN_W'(SCALE_NUM);
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = MUL_A_W'(err_r);
        mul_b  = gain_p;
      end
    endcase
  end

  // ---------------- constant divisions ----------------
  // Window average: remainder of |sum| against the estimate decides the bump.
  assign avg_rem  = (SUM_W+1)'(sum_mag) - (SUM_W+1)'(q_est * WINDOW_LENGTH);
  assign avg_bump = (avg_rem >= (SUM_W+1)'(WINDOW_LENGTH));

  // Output scaling: |(p+i+d)*255| divided by 1023.
  assign scl_x    = prod_mag[DIV_W-1:0];
  assign scl_t    = (DIV_W+1)'(scl_x) + (DIV_W+1)'(scl_x >> SCALE_SH) +
                    (DIV_W+1)'(scl_x >> (2 * SCALE_SH));
  assign scl_rem  = (DIV_W+1)'(scl_x) - (DIV_W+1)'(q_est * SCALE_DEN);
  assign scl_bump = (scl_rem >= (DIV_W+1)'(SCALE_DEN));

  // Divisors are all positive: quotient takes the dividend's sign.
  assign fix_bump = (state == ST_AVG_FIX) ? avg_bump : scl_bump;
  assign q_fix    = q_est + DRIVE_W'(fix_bump);
  assign q_signed = q_neg ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});

  // ---------------- shared divider (derivative term) ----------------
  always_comb begin
    div_req.start    = (state == ST_D_GO);
    div_req.dividend = prod_mag[DIV_W-1:0];
    div_req.divisor  = DIV_W'({ivl_r, 8'b0});
  end

  spwi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign q_s      = $signed({1'b0, div_rsp.quotient});
  assign d_signed = q_neg ? -q_s : q_s;
  assign d_term   = DTERM_W'(d_signed);

  // ---------------- clamp ----------------
  assign drv_neg     = drive_r[DRIVE_W-1];
  assign drv_mag     = drv_neg ? -drive_r : drive_r;
  assign mag_clamped = (drv_mag > DRIVE_W'(max_power)) ? max_power : drv_mag[MAG_W-1:0];
  assign out_load    = (state == ST_CLAMP) && (!m_tvalid || m_tready);

  // ---------------- sequencer and control state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      position_mode <= 1'b0;
      goal_position <= '0;
      manual_power  <= '0;
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      max_power     <= '1;
      win_idx       <= '0;
      win_valid     <= '0;
      err_sum       <= '0;
      prev_err      <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_wr) begin
        case (cfg_idx)
          REG_POSITION_MODE: position_mode <= pwdata[0];
          REG_GOAL_POSITION: goal_position <= pwdata[POS_W-1:0];
          REG_MANUAL_POWER:  manual_power  <= pwdata[MPWR_W-1:0];
          REG_GAIN_P:        gain_p        <= pwdata[GAIN_W-1:0];
          REG_GAIN_I:        gain_i        <= pwdata[GAIN_W-1:0];
          REG_GAIN_D:        gain_d        <= pwdata[GAIN_W-1:0];
          REG_MAX_POWER:     max_power     <= pwdata[MAG_W-1:0];
          default: ;
        endcase
      end

      if (win_clear) begin
        win_idx   <= '0;
        win_valid <= '0;
        err_sum   <= '0;
      end else if (s_acc && position_mode) begin
        win_idx <= win_idx_next;
      end else if (state == ST_WIN) begin
        err_sum            <= sum_new;
        win_valid[win_idx] <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            state <= position_mode ? ST_WIN : ST_CLAMP;
          end
        end
        ST_WIN:     state <= ST_AVG_MUL;
        ST_AVG_MUL: state <= ST_AVG_EST;
        ST_AVG_EST: state <= ST_AVG_FIX;
        ST_AVG_FIX: state <= ST_MUL_I;
        ST_MUL_I:   state <= ST_MUL_D;
        ST_MUL_D: begin
          prev_err <= err_r;
          state    <= ST_D_GO;
        end
        ST_D_GO: state <= ST_D_DIV;
        ST_D_DIV: begin
          if (div_rsp.done) begin
            state <= ST_SCALE_MUL;
          end
        end
        ST_SCALE_MUL: state <= ST_SCALE_EST;
        ST_SCALE_EST: state <= ST_SCALE_FIX;
        ST_SCALE_FIX: state <= ST_CLAMP;
        ST_CLAMP: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (s_acc) begin
      pos_r   <= s_pos;
      ivl_r   <= (s_ivl == '0) ? IVL_W'(1) : s_ivl;
      err_r   <= err_new;
      drive_r <= DRIVE_W'(manual_power);
    end
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    case (state)
      ST_AVG_MUL: begin
        p_r   <= shr8_tz(prod);
        q_neg <= err_sum[SUM_W-1];
      end
      ST_AVG_EST: q_est <= DRIVE_W'(prod_mag >> AVG_SHIFT);
      ST_AVG_FIX: avg_r <= ERR_W'(q_signed);
      ST_MUL_D:   i_r   <= shr8_tz(prod);
      ST_D_GO:    q_neg <= prod[PROD_W-1];
      ST_D_DIV: begin
        if (div_rsp.done) begin
          tot_r <= TOT_W'(p_r) + TOT_W'(i_r) + TOT_W'(d_term);
        end
      end
      ST_SCALE_EST: begin
        q_neg <= prod[PROD_W-1];
        q_est <= DRIVE_W'(scl_t >> SCALE_SH);
      end
      ST_SCALE_FIX: drive_r <= DRIVE_W'(q_signed);
      default: ;
    endcase
    if (out_load) begin
      out_mag <= mag_clamped;
      out_fwd <= !drv_neg && (mag_clamped != '0);
      out_pos <= pos_r;
    end
  end

  assign m_tdata = {{(M_DATA_W - POS_W - 2 - MAG_W){1'b0}}, out_pos, !out_fwd, out_fwd, out_mag};

`ifndef ASSERT_OFF
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    (err_sum <= SUM_LIMIT) && (err_sum >= -SUM_LIMIT))
    else $error("window sum out of range");

  a_result_from_clamp: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_CLAMP))
    else $error("result raised outside clamp step");

  a_manual_skips_loop: assert property (@(posedge clk) disable iff (rst)
    (s_acc && !position_mode) |=> (state == ST_CLAMP))
    else $error("manual tick entered the loop datapath");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_D_DIV))
    else $error("divider finished with no one waiting");
`endif

endmodule
